// File: src/sstf_pkg.sv
// ============================================================================
// sstf_pkg
// Shared constants and decode functions of the seven-segment formatter.
// ============================================================================
package sstf_pkg;

  // Digits in one display frame.
  localparam int DIGIT_COUNT = 8;
  // Positions over which an integer is laid out.
  localparam int NUM_POS     = 8;
  localparam int IDX_W       = 3;
  localparam int SENT_W      = 4;

  localparam logic [7:0] SEL_FIRST = 8'hFE;
  localparam logic [7:0] DOT_BIT   = 8'h80;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  // Range of integers that fit on the display.
  localparam logic signed [31:0] INT_HI = 32'sd99999999;
  localparam logic signed [31:0] INT_LO = -32'sd9999999;

  // Magnitude bits needed for the largest value shown, and packed BCD width.
  localparam int MAG_W = 27;
  localparam int BCD_W = 4 * NUM_POS;
  localparam int CNT_W = 5;

  typedef logic [7:0] seg_t;

  function automatic seg_t digit_seg(input logic [3:0] d);
    case (d)
      4'd0:    return 8'h3F;
      4'd1:    return 8'h06;
      4'd2:    return 8'h5B;
      4'd3:    return 8'h4F;
      4'd4:    return 8'h66;
      4'd5:    return 8'h6D;
      4'd6:    return 8'h7D;
      4'd7:    return 8'h07;
      4'd8:    return 8'h7F;
      4'd9:    return 8'h6F;
      default: return SEG_BLANK;
    endcase
  endfunction

  function automatic seg_t decode_char(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return digit_seg(c[3:0]);
    end
    case (c)
      "A", "a": return 8'h77;
      "B", "b": return 8'h7C;
      "C", "c": return 8'h39;
      "D", "d": return 8'h5E;
      "E", "e": return 8'h79;
      "F", "f": return 8'h71;
      "H", "h": return 8'h76;
      "i":      return 8'h04;
      "L":      return 8'h38;
      "N", "n": return 8'h37;
      "U", "u": return 8'h3E;
      "O", "o": return 8'h5C;
      "P", "p": return 8'h73;
      "R", "r": return 8'h50;
      "-":      return SEG_MINUS;
      default:  return SEG_BLANK;
    endcase
  endfunction

  // The word "error", left-aligned.
  function automatic seg_t err_code(input logic [IDX_W-1:0] idx);
    case (idx)
      3'd0:    return 8'h79;
      3'd1:    return 8'h50;
      3'd2:    return 8'h50;
      3'd3:    return 8'h5C;
      3'd4:    return 8'h50;
      default: return SEG_BLANK;
    endcase
  endfunction

  // Active-low select: SEL_FIRST rotated left by the digit position.
  function automatic logic [7:0] select_for(input logic [IDX_W-1:0] idx);
    logic [15:0] rot;
    rot = {SEL_FIRST, SEL_FIRST} << idx;
    return rot[15:8];
  endfunction

endpackage

// File: src/sstf_if.sv
// ============================================================================
// sstf_if
// Valid/ready channels of the seven-segment formatter.
// ============================================================================
interface sstf_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] value;
  logic [7:0]         char_code;
  logic               text_end;

  modport source (output valid, command, value, char_code, text_end, input ready);
  modport sink   (input valid, command, value, char_code, text_end, output ready);
endinterface

interface sstf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [7:0] digit_select;
  logic       last_digit;

  modport source (output valid, segments, digit_select, last_digit, input ready);
  modport sink   (input valid, segments, digit_select, last_digit, output ready);
endinterface

// File: src/seven_segment_text_and_integer_formatter_unit.sv
// ============================================================================
// seven_segment_text_and_integer_formatter_unit
// Formats text characters or a signed integer into seven-segment digit items.
// ============================================================================
// An integer is accepted, converted to BCD one magnitude bit at a time (the
// conversion is skipped when out of range), then handed out as 8 digits.
// A text character is accepted, then hands out the digits it releases.
// Only one item is in the block at a time: the input is held off until the
// last item is through.
// Reset: synchronous, active low; clears the text state and the output.
// ============================================================================
module seven_segment_text_and_integer_formatter_unit (
  input  logic             clk,
  input  logic             rst_n,
  sstf_in_if.sink          in_ch,
  sstf_out_if.source       out_ch
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an input item
  localparam logic [1:0] ST_CONV = 2'd1;  // shift-add-3 conversion, one bit a cycle
  localparam logic [1:0] ST_INT  = 2'd2;  // handing out the integer frame
  localparam logic [1:0] ST_TXT  = 2'd3;  // handing out digits released by text

  localparam logic [sstf_pkg::CNT_W-1:0] CNT_LAST =
    sstf_pkg::CNT_W'(sstf_pkg::MAG_W - 1);
  localparam logic [sstf_pkg::IDX_W-1:0] IDX_LAST =
    sstf_pkg::IDX_W'(sstf_pkg::DIGIT_COUNT - 1);
  localparam logic [sstf_pkg::IDX_W-1:0] POS_ONES =
    sstf_pkg::IDX_W'(sstf_pkg::NUM_POS - 1);
  localparam logic [sstf_pkg::IDX_W-1:0] POS_TENS =
    sstf_pkg::IDX_W'(sstf_pkg::NUM_POS - 2);
  localparam logic [sstf_pkg::SENT_W-1:0] SENT_FULL =
    sstf_pkg::SENT_W'(sstf_pkg::DIGIT_COUNT);

  // Control state.
  logic [1:0]                   state_r, state_nxt;
  logic                         pending_valid_r, pending_valid_nxt;
  logic                         pending_dotted_r, pending_dotted_nxt;
  logic [sstf_pkg::SENT_W-1:0]  digits_sent_r, digits_sent_nxt;
  logic                         a_pend_r, a_pend_nxt;   // old pending digit to send
  logic                         b_pend_r, b_pend_nxt;   // new pending digit to flush
  logic                         pad_r, pad_nxt;         // end of text: pad and reset
  logic                         started_r, started_nxt; // a significant digit was sent
  logic [sstf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Payload state.
  sstf_pkg::seg_t               pending_code_r, pending_code_nxt;
  sstf_pkg::seg_t               a_code_r, a_code_nxt;
  logic                         neg_r, neg_nxt;
  logic                         err_r, err_nxt;
  logic [sstf_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [sstf_pkg::MAG_W-1:0]   mag_r, mag_nxt;
  sstf_pkg::seg_t               out_seg_r, out_seg_nxt;
  logic [7:0]                   out_sel_r, out_sel_nxt;
  logic                         out_last_r, out_last_nxt;

  // Working signals.
  logic                         in_acc;
  logic                         slot_free;
  logic                         emit;
  sstf_pkg::seg_t               emit_code;
  logic [sstf_pkg::IDX_W-1:0]   idx;
  logic [sstf_pkg::BCD_W-1:0]   bcd_adj;
  logic [31:0]                  mag_full;
  logic                         in_neg;
  logic                         in_err;
  logic [3:0]                   cur_digit;
  logic [3:0]                   next_digit;
  logic                         significant;
  sstf_pkg::seg_t               int_code;
  logic                         dot_case;
  logic [sstf_pkg::SENT_W-1:0]  sent_after;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.segments     = out_seg_r;
  assign out_ch.digit_select = out_sel_r;
  assign out_ch.last_digit   = out_last_r;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign idx       = digits_sent_r[sstf_pkg::IDX_W-1:0];

  // Range check and magnitude of the integer, taken at the accept edge.
  assign in_neg   = in_ch.value[31];
  assign in_err   = (in_ch.value > sstf_pkg::INT_HI) || (in_ch.value < sstf_pkg::INT_LO);
  assign mag_full = in_neg ? (32'd0 - in_ch.value) : in_ch.value;

  // Add-3 correction on every BCD digit ahead of the next shift.
  always_comb begin
    for (int i = 0; i < sstf_pkg::NUM_POS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                    : bcd_r[4*i +: 4];
    end
  end

  // The BCD word shifts left by one digit per emitted position, so the
  // current digit sits in the top nibble and its right neighbor below it.
  // A digit is shown once a nonzero digit has been seen, and the ones place
  // is always shown. A negative value puts its minus sign at the blank
  // position just left of the first shown digit.
  assign cur_digit   = bcd_r[sstf_pkg::BCD_W-1 -: 4];
  assign next_digit  = bcd_r[sstf_pkg::BCD_W-5 -: 4];
  assign significant = started_r || (cur_digit != 4'd0) || (idx == POS_ONES);

  always_comb begin
    if (err_r) begin
      int_code = sstf_pkg::err_code(idx);
    end else if (significant) begin
      int_code = sstf_pkg::digit_seg(cur_digit);
    end else if (neg_r && ((next_digit != 4'd0) || (idx == POS_TENS))) begin
      int_code = sstf_pkg::SEG_MINUS;
    end else begin
      int_code = sstf_pkg::SEG_BLANK;
    end
  end

  // A dot marks the held digit when that digit has no dot yet.
  assign dot_case   = (in_ch.char_code == ".") && pending_valid_r && !pending_dotted_r;
  assign sent_after = digits_sent_r + sstf_pkg::SENT_W'(pending_valid_r);

  always_comb begin
    state_nxt          = state_r;
    pending_valid_nxt  = pending_valid_r;
    pending_dotted_nxt = pending_dotted_r;
    pending_code_nxt   = pending_code_r;
    digits_sent_nxt    = digits_sent_r;
    a_pend_nxt         = a_pend_r;
    a_code_nxt         = a_code_r;
    b_pend_nxt         = b_pend_r;
    pad_nxt            = pad_r;
    started_nxt        = started_r;
    cnt_nxt            = cnt_r;
    neg_nxt            = neg_r;
    err_nxt            = err_r;
    bcd_nxt            = bcd_r;
    mag_nxt            = mag_r;
    emit               = 1'b0;
    emit_code          = sstf_pkg::SEG_BLANK;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_ch.command) begin
            // An integer drops any text frame in progress.
            pending_valid_nxt  = 1'b0;
            pending_dotted_nxt = 1'b0;
            pending_code_nxt   = sstf_pkg::SEG_BLANK;
            digits_sent_nxt    = '0;
            started_nxt        = 1'b0;
            neg_nxt            = in_neg;
            err_nxt            = in_err;
            bcd_nxt            = '0;
            mag_nxt            = mag_full[sstf_pkg::MAG_W-1:0];
            cnt_nxt            = '0;
            state_nxt          = in_err ? ST_INT : ST_CONV;
          end else begin
            if (dot_case) begin
              pending_code_nxt   = pending_code_r | sstf_pkg::DOT_BIT;
              pending_dotted_nxt = 1'b1;
              a_pend_nxt         = 1'b0;
            end else begin
              // The held digit is released; the new character is held
              // only while the frame still has room for it.
              a_pend_nxt = pending_valid_r;
              a_code_nxt = pending_code_r;
              if (sent_after < SENT_FULL) begin
                pending_code_nxt   = sstf_pkg::decode_char(in_ch.char_code);
                pending_valid_nxt  = 1'b1;
                pending_dotted_nxt = 1'b0;
              end else begin
                pending_valid_nxt  = 1'b0;
              end
            end
            b_pend_nxt = in_ch.text_end && (dot_case || (sent_after < SENT_FULL));
            pad_nxt    = in_ch.text_end;
            state_nxt  = ST_TXT;
          end
        end
      end

      ST_CONV: begin
        bcd_nxt = {bcd_adj[sstf_pkg::BCD_W-2:0], mag_r[sstf_pkg::MAG_W-1]};
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_INT;
        end
      end

      ST_INT: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_code   = int_code;
          started_nxt = significant;
          bcd_nxt     = bcd_r << 4;
          if (idx == IDX_LAST) begin
            digits_sent_nxt = '0;
            state_nxt       = ST_IDLE;
          end else begin
            digits_sent_nxt = digits_sent_r + 1'b1;
          end
        end
      end

      ST_TXT: begin
        if (a_pend_r) begin
          if (slot_free) begin
            emit            = 1'b1;
            emit_code       = a_code_r;
            a_pend_nxt      = 1'b0;
            digits_sent_nxt = digits_sent_r + 1'b1;
          end
        end else if (b_pend_r) begin
          if (slot_free) begin
            emit              = 1'b1;
            emit_code         = pending_code_r;
            b_pend_nxt        = 1'b0;
            pending_valid_nxt = 1'b0;
            digits_sent_nxt   = digits_sent_r + 1'b1;
          end
        end else if (pad_r && (digits_sent_r < SENT_FULL)) begin
          if (slot_free) begin
            emit            = 1'b1;
            emit_code       = sstf_pkg::SEG_BLANK;
            digits_sent_nxt = digits_sent_r + 1'b1;
          end
        end else begin
          // End of text returns the text state to its reset values.
          if (pad_r) begin
            pending_valid_nxt  = 1'b0;
            pending_dotted_nxt = 1'b0;
            pending_code_nxt   = sstf_pkg::SEG_BLANK;
            digits_sent_nxt    = '0;
            pad_nxt            = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded on an emit, emptied when the sink takes the item.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_seg_nxt   = out_seg_r;
    out_sel_nxt   = out_sel_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_seg_nxt   = emit_code;
      out_sel_nxt   = sstf_pkg::select_for(idx);
      out_last_nxt  = (idx == IDX_LAST);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      pending_valid_r  <= 1'b0;
      pending_dotted_r <= 1'b0;
      pending_code_r   <= sstf_pkg::SEG_BLANK;
      digits_sent_r    <= '0;
      a_pend_r         <= 1'b0;
      b_pend_r         <= 1'b0;
      pad_r            <= 1'b0;
      started_r        <= 1'b0;
      cnt_r            <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      pending_valid_r  <= pending_valid_nxt;
      pending_dotted_r <= pending_dotted_nxt;
      pending_code_r   <= pending_code_nxt;
      digits_sent_r    <= digits_sent_nxt;
      a_pend_r         <= a_pend_nxt;
      b_pend_r         <= b_pend_nxt;
      pad_r            <= pad_nxt;
      started_r        <= started_nxt;
      cnt_r            <= cnt_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_code_r   <= a_code_nxt;
    neg_r      <= neg_nxt;
    err_r      <= err_nxt;
    bcd_r      <= bcd_nxt;
    mag_r      <= mag_nxt;
    out_seg_r  <= out_seg_nxt;
    out_sel_r  <= out_sel_nxt;
    out_last_r <= out_last_nxt;
  end

  // The frame position never passes the digit count.
  a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digits_sent_r <= SENT_FULL)
    else $error("digit position ran past the frame");

  // A held text digit always has room left in its frame.
  a_pending_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && pending_valid_r |-> digits_sent_r < SENT_FULL)
    else $error("held digit without room in the frame");

  // An accepted integer starts a fresh frame at the first position.
  a_int_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ch.command |=> digits_sent_r == '0 && !pending_valid_r &&
                                 (state_r == ST_CONV || state_r == ST_INT))
    else $error("integer item did not restart the frame");

  // The last digit of a frame carries the matching select.
  a_last_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_sel_r == sstf_pkg::select_for(IDX_LAST))
    else $error("last digit flagged at the wrong select");

endmodule

// File: sim/tb_top.sv
// ============================================================================
// tb_top
// Testbench of the seven-segment text and integer formatter. Items go in
// through a valid/ready channel in random bursts while the result side
// stalls on a pattern of its own. A behavioral model in this file predicts
// every digit item, and a checker compares each one as it leaves the block.
// ============================================================================
module tb_top;

  // Command codes of the input item.
  localparam logic CMD_INTEGER = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // The receiver holds off this long once during the pressure test.
  localparam int HOLD_CYCLES   = 400;
  // Cycles with no handshake on either channel before the run is abandoned.
  // The longest correct quiet stretch is the hold-off plus one item.
  localparam int IDLE_LIMIT    = 4000;
  // Cycles left after the last digit so that a late or extra item shows up.
  localparam int TAIL_CYCLES   = 80;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
    logic [7:0]         char_code;
    logic               text_end;
  } fmt_item_t;

  typedef struct packed {
    sstf_pkg::seg_t segments;
    logic [7:0]     digit_select;
    logic           last_digit;
  } digit_t;

  localparam sstf_pkg::seg_t NUMERAL_GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic clk = 1'b0;
  logic rst_n;

  sstf_in_if  in_ch ();
  sstf_out_if out_ch ();

  seven_segment_text_and_integer_formatter_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the text state of the block: the digit held
  // back waiting for a possible dot, whether it already has its dot, and how
  // many digits of the current frame have gone out.
  // --------------------------------------------------------------------------
  digit_t          digit_q [$];
  sstf_pkg::seg_t  held_glyph;
  logic            held_valid;
  logic            held_dotted;
  int              frame_pos;

  int         fail_count = 0;
  logic       hold_req   = 1'b0;
  logic       offering   = 1'b0;
  int         burst_left = 1;

  // Segment pattern of one text character; anything not listed is blank.
  function automatic sstf_pkg::seg_t glyph_for_char(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return NUMERAL_GLYPH[c - "0"];
    end
    case (c)
      "A", "a": return 8'h77;
      "B", "b": return 8'h7C;
      "C", "c": return 8'h39;
      "D", "d": return 8'h5E;
      "E", "e": return 8'h79;
      "F", "f": return 8'h71;
      "H", "h": return 8'h76;
      "i":      return 8'h04;
      "L":      return 8'h38;
      "N", "n": return 8'h37;
      "U", "u": return 8'h3E;
      "O", "o": return 8'h5C;
      "P", "p": return 8'h73;
      "R", "r": return 8'h50;
      "-":      return sstf_pkg::SEG_MINUS;
      default:  return sstf_pkg::SEG_BLANK;
    endcase
  endfunction

  function automatic void clear_text_state();
    held_glyph  = sstf_pkg::SEG_BLANK;
    held_valid  = 1'b0;
    held_dotted = 1'b0;
    frame_pos   = 0;
  endfunction

  // Queues one digit at the current frame position. The select is a single
  // low bit that walks left from bit 0 as the frame advances.
  function automatic void push_digit(input sstf_pkg::seg_t glyph);
    digit_t d;
    int     idx;
    idx            = frame_pos % 8;
    d.segments     = glyph;
    d.digit_select = ~(8'h01 << idx);
    d.last_digit   = (idx == sstf_pkg::DIGIT_COUNT - 1);
    digit_q.push_back(d);
    frame_pos      = (frame_pos + 1) % 16;
  endfunction

  // Works out the digits that one accepted item releases.
  function automatic void predict_digits(input fmt_item_t it);
    sstf_pkg::seg_t glyphs [8];
    int   v;
    int   mag;
    int   pos;
    logic neg;
    if (it.command == CMD_INTEGER) begin
      v = it.value;
      foreach (glyphs[i]) glyphs[i] = sstf_pkg::SEG_BLANK;
      if (v > sstf_pkg::INT_HI || v < sstf_pkg::INT_LO) begin
        // The word "error" from the left edge.
        glyphs[0] = 8'h79;
        glyphs[1] = 8'h50;
        glyphs[2] = 8'h50;
        glyphs[3] = 8'h5C;
        glyphs[4] = 8'h50;
      end else begin
        neg = (v < 0);
        mag = neg ? -v : v;
        pos = 7;
        do begin
          glyphs[pos] = NUMERAL_GLYPH[mag % 10];
          mag         = mag / 10;
          pos--;
        end while (mag != 0 && pos >= 0);
        if (neg && pos >= 0) glyphs[pos] = sstf_pkg::SEG_MINUS;
      end
      // An integer throws away any text frame in progress.
      clear_text_state();
      for (int i = 0; i < sstf_pkg::DIGIT_COUNT && i < 8; i++) push_digit(glyphs[i]);
      clear_text_state();
      return;
    end

    if (it.char_code == "." && held_valid && !held_dotted) begin
      held_glyph  = held_glyph | sstf_pkg::DOT_BIT;
      held_dotted = 1'b1;
    end else begin
      if (held_valid) begin
        push_digit(held_glyph);
        held_valid = 1'b0;
      end
      // Past a full frame the character is dropped.
      if (frame_pos < sstf_pkg::DIGIT_COUNT) begin
        held_glyph  = glyph_for_char(it.char_code);
        held_valid  = 1'b1;
        held_dotted = 1'b0;
      end
    end

    if (it.text_end) begin
      if (held_valid && frame_pos < sstf_pkg::DIGIT_COUNT) push_digit(held_glyph);
      while (frame_pos < sstf_pkg::DIGIT_COUNT) push_digit(sstf_pkg::SEG_BLANK);
      clear_text_state();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Item builders. Fields that the command ignores get random filler.
  // --------------------------------------------------------------------------
  function automatic fmt_item_t text_item(input logic [7:0] c, input logic last);
    fmt_item_t it;
    it.command   = CMD_TEXT;
    it.value     = $urandom;
    it.char_code = c;
    it.text_end  = last;
    return it;
  endfunction

  function automatic fmt_item_t int_item(input logic signed [31:0] v);
    fmt_item_t it;
    it.command   = CMD_INTEGER;
    it.value     = v;
    it.char_code = 8'($urandom_range(0, 255));
    it.text_end  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Mostly characters the block can show, plenty of dots, some raw bytes.
  function automatic logic [7:0] pick_char();
    string shown;
    int    r;
    shown = "0123456789AaBbCcDdEeFfHhiLNnUuOoPpRr-*";
    r     = $urandom_range(0, 99);
    if (r < 50) return shown[$urandom_range(0, shown.len() - 1)];
    if (r < 75) return ".";
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 6))
      0:       return $urandom_range(0, 99);
      1:       return $urandom_range(0, 99999999);
      2:       return -$signed({1'b0, 31'($urandom_range(0, 9999999))});
      3:       return -$signed({1'b0, 31'($urandom_range(1, 999))});
      4: begin
        case ($urandom_range(0, 5))
          0:       return 32'sd99999999;
          1:       return 32'sd100000000;
          2:       return -32'sd9999999;
          3:       return -32'sd10000000;
          4:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender. send_item leaves valid high so that a following item goes out
  // back to back; lower_valid drops it once, and only when it is up.
  // --------------------------------------------------------------------------
  task automatic send_item(input fmt_item_t it);
    in_ch.valid     <= 1'b1;
    in_ch.command   <= it.command;
    in_ch.value     <= it.value;
    in_ch.char_code <= it.char_code;
    in_ch.text_end  <= it.text_end;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_digits(it);
  endtask

  task automatic lower_valid();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Bursts of random length with random gaps; now and then a long burst
  // gives a stretch with no idling at all.
  task automatic offer(input fmt_item_t it);
    send_item(it);
    burst_left--;
    if (burst_left <= 0) begin
      lower_valid();
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
    end
  endtask

  task automatic offer_text(input string s);
    for (int i = 0; i < s.len(); i++) offer(text_item(s[i], i == s.len() - 1));
  endtask

  // Pauses the sender until every predicted digit has come out. The first
  // edge is always waited so that valid never falls and rises in one step.
  task automatic wait_digits_drained();
    lower_valid();
    @(posedge clk);
    while (digit_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. It switches between several stall patterns, one of which is
  // never to stall. On request it holds off for HOLD_CYCLES in one piece.
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int phase_left;
    int tick;
    mode         = 0;
    phase_left   = 0;
    tick         = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 120);
        end
        phase_left--;
        tick++;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= (tick % 5) > 1;
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every digit item that leaves is held against the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    digit_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digit_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digit seg=%h sel=%h last=%b",
                                  out_ch.segments, out_ch.digit_select,
                                  out_ch.last_digit));
      end else begin
        want = digit_q.pop_front();
        if (out_ch.segments !== want.segments)
          report_mismatch($sformatf("segments %h, expected %h",
                                    out_ch.segments, want.segments));
        if (out_ch.digit_select !== want.digit_select)
          report_mismatch($sformatf("digit_select %h, expected %h",
                                    out_ch.digit_select, want.digit_select));
        if (out_ch.last_digit !== want.last_digit)
          report_mismatch($sformatf("last_digit %b, expected %b",
                                    out_ch.last_digit, want.last_digit));
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Range edges, zero, the most negative value shown, and the 32-bit ends.
  task automatic test_integer_limits();
    offer(int_item(32'sd0));
    offer(int_item(32'sd99999999));
    offer(int_item(32'sd100000000));
    offer(int_item(-32'sd9999999));
    offer(int_item(-32'sd10000000));
    offer(int_item(32'sh7FFFFFFF));
    offer(int_item(32'sh80000000));
    wait_digits_drained();
  endtask

  // A dot on a digit, a second dot that turns into a blank digit, a dot with
  // nothing before it, and a dot that lands on such a blank digit.
  task automatic test_dot_rules();
    offer_text("A..");
    offer_text("..u");
    wait_digits_drained();
  endtask

  // Nine characters: the ninth falls outside the frame and is dropped.
  task automatic test_text_overflow();
    offer_text("012345678");
    wait_digits_drained();
  endtask

  // An integer arriving with a text frame half built replaces that frame.
  task automatic test_integer_breaks_text();
    offer(text_item("1", 1'b0));
    offer(text_item("2", 1'b0));
    offer(int_item(32'sd12));
    wait_digits_drained();
  endtask

  // The receiver holds off while the sender keeps offering, so the block
  // fills up and holds its input off in turn.
  task automatic test_output_hold_off();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_item(text_item(pick_char(), 1'b0));
    send_item(int_item(pick_value()));
    for (int i = 0; i < 5; i++) send_item(text_item(pick_char(), i == 4));
    lower_valid();
    while (hold_req) @(posedge clk);
    wait_digits_drained();
  endtask

  // Mostly whole texts with random content, plus integers, and some broken
  // texts: lone characters and texts that run past a frame.
  task automatic test_random_mix(input int item_budget);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < item_budget) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 9);
        for (int i = 0; i < len; i++) offer(text_item(pick_char(), i == len - 1));
        sent += len;
      end else if (r < 88) begin
        offer(int_item(pick_value()));
        sent++;
      end else begin
        offer(text_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        sent++;
      end
      if ($urandom_range(0, 24) == 0) wait_digits_drained();
    end
  endtask

  initial begin
    clear_text_state();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_INTEGER;
    in_ch.value     <= '0;
    in_ch.char_code <= '0;
    in_ch.text_end  <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_integer_limits();
    test_dot_rules();
    test_text_overflow();
    test_integer_breaks_text();
    test_output_hold_off();
    test_random_mix(250);

    wait_digits_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (digit_q.size() != 0)
      report_mismatch($sformatf("%0d digits never arrived", digit_q.size()));
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: seven_segment_text_and_integer_formatter_unit.f
src/sstf_pkg.sv
src/sstf_if.sv
src/seven_segment_text_and_integer_formatter_unit.sv
sim/tb_top.sv
